// ===== src/suks_pkg.sv =====
// shared types and constants for the sorted unique key set
`timescale 1ns / 1ps
`default_nettype none
package suks_pkg;

   localparam int KEY_W   = 32;
   localparam int FIELD_W = 5;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_DUPLICATE = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [KEY_W-1:0]   key;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [FIELD_W-1:0]    position;
      logic [FIELD_W-1:0]    count;
   } rsp_type;

   // per-cycle commands broadcast to every cell
   typedef struct packed {
      logic compare;
      logic shift_ins;
      logic shift_del;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== src/suks_chan_if.sv =====
// valid/ready channel carrying one word of a given payload type
`timescale 1ns / 1ps
`default_nettype none
interface suks_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/sorted_unique_key_set.sv =====
// sorted unique key set: a chain of compare-and-shift cells
// one request word is accepted and compared in all cells in the next cycle (S_CMP);
// it is applied (shift, count update, result) in S_APPLY once the result register
// is free or being taken; the result word is registered at that commit, and a new
// request is taken only in idle or in the same cycle as the commit
// reset clears the key count, the controller and the result valid; keys are not reset
`timescale 1ns / 1ps
`default_nettype none
module sorted_unique_key_set #(
   parameter int CAPACITY = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   suks_chan_if.sink   req_if,
   suks_chan_if.source rsp_if
);
   import suks_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CMP   = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   cell_ctrl_type           ctrl;
   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0]     cell_lt;
   logic [CAPACITY-1:0]     cell_eq;

   logic                    accept;
   logic                    commit;
   logic                    hit;
   logic                    full;
   logic [CW-1:0]           pos;
   logic                    do_ins;
   logic                    do_del;

   assign commit       = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = (state_ff == S_IDLE) || commit;
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // the cells below the insertion point hold smaller keys, so the lt flags form a
   // prefix; the boundary is one-hot and encodes the position directly
   always_comb begin
      pos = '0;
      hit = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (!cell_lt[i] && (i == 0 || cell_lt[(i == 0) ? 0 : i - 1])) begin
            pos = pos | CW'(i);
            hit = hit | cell_eq[i];
         end
      end
      if (cell_lt[CAPACITY-1]) begin
         pos = CW'(CAPACITY);
      end
   end

   assign full   = (count_ff == CW'(CAPACITY));
   assign do_ins = commit && (cmd_ff == CMD_INSERT) && !hit && !full;
   assign do_del = commit && (cmd_ff == CMD_DELETE) && hit;

   always_comb begin
      ctrl.compare   = (state_ff == S_CMP);
      ctrl.shift_ins = do_ins;
      ctrl.shift_del = do_del;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [KEY_W-1:0] left_key;
      logic signed [KEY_W-1:0] right_key;
      logic                    left_lt;

      if (g == 0) begin : g_first
         assign left_key = key_ff;
         assign left_lt  = 1'b1;
      end else begin : g_mid
         assign left_key = cell_key[g-1];
         assign left_lt  = cell_lt[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[g];
      end else begin : g_inner
         assign right_key = cell_key[g+1];
      end

      suks_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .valid     (count_ff > CW'(g)),
         .key_in    (key_ff),
         .left_key  (left_key),
         .left_lt   (left_lt),
         .right_key (right_key),
         .key_ff    (cell_key[g]),
         .lt_ff     (cell_lt[g]),
         .eq_ff     (cell_eq[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = rsp_ff;
      if (commit) begin
         unique case (cmd_ff)
            CMD_INSERT: begin
               if (hit) begin
                  rsp_in.status = ST_DUPLICATE;
               end else if (full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.status = ST_DONE;
                  count_in      = count_ff + CW'(1);
               end
            end
            CMD_DELETE: begin
               if (hit) begin
                  rsp_in.status = ST_DONE;
                  count_in      = count_ff - CW'(1);
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
            CMD_SEARCH: begin
               rsp_in.status = hit ? ST_DONE : ST_NOT_FOUND;
            end
            CMD_CLEAR: begin
               rsp_in.status = ST_DONE;
               count_in      = '0;
            end
            default: begin
               rsp_in.status = ST_DONE;
            end
         endcase
         rsp_in.position = (cmd_ff == CMD_CLEAR) ? '0 : FIELD_W'(pos);
         rsp_in.count    = FIELD_W'(count_in);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_CMP;
         S_CMP:   state_in = S_APPLY;
         S_APPLY: if (commit) state_in = accept ? S_CMP : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_if.payload.cmd;
         key_ff <= req_if.payload.key;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/suks_cell.sv =====
// one cell of the sorted chain: holds a key and its compare flags
`timescale 1ns / 1ps
`default_nettype none
module suks_cell (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire suks_pkg::cell_ctrl_type                ctrl,
   input  wire logic                                   valid,
   input  wire logic signed [suks_pkg::KEY_W-1:0]      key_in,
   input  wire logic signed [suks_pkg::KEY_W-1:0]      left_key,
   input  wire logic                                   left_lt,
   input  wire logic signed [suks_pkg::KEY_W-1:0]      right_key,
   output logic signed [suks_pkg::KEY_W-1:0]           key_ff,
   output logic                                        lt_ff,
   output logic                                        eq_ff
);
   import suks_pkg::*;

   logic signed [KEY_W-1:0] key_in_next;
   logic                    lt_in;
   logic                    eq_in;

   always_comb begin
      key_in_next = key_ff;
      // cells at/past the point move right on insert, new key at boundary; left on delete
      if (ctrl.shift_ins && !lt_ff) begin
         key_in_next = left_lt ? key_in : left_key;
      end else if (ctrl.shift_del && !lt_ff) begin
         key_in_next = right_key;
      end
   end

   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctrl.compare) begin
         lt_in = valid && (key_ff < key_in);
         eq_in = valid && (key_ff == key_in);
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
   end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the sorted unique key set: directed, back-pressure and random traffic
`timescale 1ns / 1ps
module testbench;
   import suks_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_IDLE    = 17;
   localparam int POOL_SIZE   = 20;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   logic clock;
   logic reset;

   suks_chan_if #(.payload_type(req_type)) req_chan ();
   suks_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   sorted_unique_key_set #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_chan),
      .rsp_if(rsp_chan)
   );

   // predicted set contents, ascending
   logic signed [KEY_W-1:0] model_keys[CAPACITY];
   int                      model_size;

   rsp_type pending_responses[$];
   logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

   int  requests_accepted;
   int  results_checked;
   int  mismatches;
   int  status_seen[4];
   int  peak_size;
   int  hold_off_cycles;
   bit  sender_idles;
   bit  sink_idles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
   end

   // compute the result of one request and update the predicted set
   function automatic rsp_type apply_request(req_type r);
      rsp_type                 res;
      logic signed [KEY_W-1:0] k;
      int                      slot;
      logic                    found;
      k          = r.key;
      slot       = 0;
      res.status = ST_DONE;
      if (r.cmd == CMD_CLEAR) begin
         model_size = 0;
      end else begin
         while (slot < model_size && model_keys[slot] < k) slot++;
         found = (slot < model_size) && (model_keys[slot] == k);
         case (r.cmd)
            CMD_INSERT: begin
               if (found) begin
                  res.status = ST_DUPLICATE;
               end else if (model_size >= CAPACITY) begin
                  res.status = ST_FULL;
               end else begin
                  for (int i = model_size; i > slot; i--) model_keys[i] = model_keys[i-1];
                  model_keys[slot] = k;
                  model_size++;
               end
            end
            CMD_DELETE: begin
               if (found) begin
                  for (int i = slot; i + 1 < model_size; i++) model_keys[i] = model_keys[i+1];
                  model_size--;
               end else begin
                  res.status = ST_NOT_FOUND;
               end
            end
            default: begin
               if (!found) res.status = ST_NOT_FOUND;
            end
         endcase
      end
      res.position = slot[FIELD_W-1:0];
      res.count    = model_size[FIELD_W-1:0];
      return res;
   endfunction

   // predict on accepted requests, compare on accepted results
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            want = apply_request(req_chan.payload);
            pending_responses.push_back(want);
            status_seen[want.status]++;
            if (model_size > peak_size) peak_size = model_size;
            requests_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            results_checked++;
            if (pending_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with nothing expected: status %s pos %0d count %0d",
                           $realtime, got.status.name(), got.position, got.count);
            end else begin
               want = pending_responses.pop_front();
               if (got.status !== want.status || got.position !== want.position ||
                   got.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch: expected status %s pos %0d count %0d",
                              $realtime, want.status.name(), want.position, want.count);
                     $display("%0t:           got status %s pos %0d count %0d",
                              $realtime, got.status.name(), got.position, got.count);
                  end
               end
            end
         end
      end
   end

   // result side: random stalls per word, plus an optional long hold-off
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         stall = sink_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               CYCLE_LIMIT, pending_responses.size());
      $display("*** FAILED ***");
      $finish;
   end

   // offer one request word and hold it until accepted
   task automatic send_request(input cmd_type c, input logic signed [KEY_W-1:0] k);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.payload.cmd = c;
      req_chan.payload.key = k;
      req_chan.valid       = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic test_edge_keys();
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
      send_request(CMD_INSERT, KEY_MIN);
      send_request(CMD_INSERT, KEY_MAX);
      send_request(CMD_INSERT, 32'sd0);
      send_request(CMD_INSERT, KEY_MAX);   // duplicate
      send_request(CMD_SEARCH, KEY_MIN);
      send_request(CMD_SEARCH, 32'sd5);    // absent, lands between 0 and max
      send_request(CMD_DELETE, -32'sd7);   // absent
      send_request(CMD_DELETE, 32'sd0);
      send_request(CMD_SEARCH, 32'sd0);
   endtask

   task automatic test_full_store();
      for (int i = 0; i < CAPACITY - 2; i++)
         send_request(CMD_INSERT, (i - 7) * 1000003);
      send_request(CMD_INSERT, 32'sd42);   // refused, store full
      send_request(CMD_INSERT, KEY_MAX);   // duplicate wins over full
      send_request(CMD_CLEAR, $urandom);
   endtask

   // receiver holds off while the sender streams back to back
   task automatic test_back_pressure();
      sender_idles    = 1'b0;
      sink_idles      = 1'b0;
      hold_off_cycles = 150;
      for (int i = 0; i < 24; i++)
         send_request(i % 3 == 0 ? CMD_SEARCH : CMD_INSERT, $urandom_range(0, 40) - 20);
   endtask

   function automatic logic signed [KEY_W-1:0] pool_entry();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $urandom_range(0, 16) - 8;
         2:       return $urandom_range(0, 1) ? KEY_MIN + $urandom_range(0, 2)
                                              : KEY_MAX - $urandom_range(0, 2);
         default: return $urandom_range(0, 2000) - 1000;
      endcase
   endfunction

   // phases with a small key pool so hits, duplicates and a full store are common
   task automatic test_random_traffic(input int n_items);
      int sent;
      int phase_len;
      int insert_pct;
      int roll;
      logic signed [KEY_W-1:0] k;
      sent = 0;
      while (sent < n_items) begin
         phase_len  = $urandom_range(20, 60);
         insert_pct = $urandom_range(25, 70);
         sender_idles = $urandom_range(0, 2) != 0;
         sink_idles   = $urandom_range(0, 2) != 0;
         for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = pool_entry();
         for (int i = 0; i < phase_len && sent < n_items; i++) begin
            k    = $urandom_range(0, 9) == 0 ? $urandom
                                             : key_pool[$urandom_range(0, POOL_SIZE - 1)];
            roll = $urandom_range(0, 99);
            if (roll < 3)
               send_request(CMD_CLEAR, k);
            else if (roll < 3 + insert_pct)
               send_request(CMD_INSERT, k);
            else if (roll < 3 + insert_pct + (97 - insert_pct) / 2)
               send_request(CMD_DELETE, k);
            else
               send_request(CMD_SEARCH, k);
            sent++;
         end
      end
   endtask

   initial begin
      model_size        = 0;
      peak_size         = 0;
      requests_accepted = 0;
      results_checked   = 0;
      mismatches        = 0;
      hold_off_cycles   = 0;
      sender_idles      = 1'b0;
      sink_idles        = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_edge_keys();
      test_full_store();
      test_back_pressure();
      test_random_traffic(500);

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_responses.size() != 0) mismatches++;

      $display("covered %0d requests, %0d results checked, set peaked at %0d of %0d keys",
               requests_accepted, results_checked, peak_size, CAPACITY);
      $display("statuses: done %0d, duplicate %0d, not found %0d, full %0d; mismatches %0d",
               status_seen[ST_DONE], status_seen[ST_DUPLICATE], status_seen[ST_NOT_FOUND],
               status_seen[ST_FULL], mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sorted_unique_key_set.f =====
src/suks_pkg.sv
src/suks_chan_if.sv
src/suks_cell.sv
src/sorted_unique_key_set.sv
dv/testbench.sv
